FILE: design/segregated_free_list_allocator_core_assert.svh
// Assertion macros for the allocator core. Define ASSERT_OFF to drop them.
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle as ante
`define SFLA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Check that cons holds in the cycle after ante
`define SFLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`else

`define SFLA_ASSERT_NOW(lbl, ante, cons)
`define SFLA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: design/sfla_pkg.sv
package sfla_pkg;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERSIZE = 2'd1;
  localparam logic [1:0] ST_OOM      = 2'd2;

  // Refill count reset value and clamp limit
  localparam logic [5:0] REFILL_RESET = 6'd20;
  localparam logic [5:0] REFILL_MAX   = 6'd32;

  typedef struct packed {
    logic        operation;
    logic [15:0] size;
    logic [15:0] address;
  } in_t;

  typedef struct packed {
    logic [15:0] address_res;
    logic [1:0]  status;
  } out_t;

endpackage

FILE: design/segregated_free_list_allocator_core.sv
// Channel   Ports                        Handshake
// request   start, busy, in_data         beat taken when start && !busy
// result    out_valid, out_data          one-cycle strobe, cannot stall
// config    cfg_we, cfg_wdata            write when cfg_we, no wait
//
// Oversize answers from idle; free and an allocate from a non-empty list read the head first.
// A refill adds a multiply, a leftover check, a quotient count,
// an arena grow or a head-memory scan over this and the larger classes,
// then one link-memory write per carved object after the first.
// Reset is synchronous; head lists start empty through per-class valid bits,
// so no clearing pass is needed. Results cannot be stalled by the receiver.
`include "segregated_free_list_allocator_core_assert.svh"

module segregated_free_list_allocator_core #(
  parameter int POOL_BYTES  = 65536,
  parameter int CLASS_COUNT = 16,
  parameter int GRANULE     = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  sfla_pkg::in_t    in_data,
  output logic             out_valid,
  output sfla_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [5:0]       cfg_wdata
);

  localparam int GB         = $clog2(GRANULE);
  localparam int CW         = $clog2(CLASS_COUNT);
  localparam int LINK_DEPTH = POOL_BYTES / GRANULE;
  localparam int LW         = $clog2(LINK_DEPTH);
  localparam int AW         = $clog2(POOL_BYTES) + 1;
  localparam int VW         = ((AW > 17) ? AW : 17) + 1;
  localparam int MAX_SMALL  = CLASS_COUNT * GRANULE;
  localparam int NW         = $clog2(MAX_SMALL) + 1;
  localparam int TW         = NW + 6;
  localparam int GW         = ((VW > TW) ? VW : TW) + 2;

  typedef struct packed {
    logic          nul;
    logic [VW-1:0] addr;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HRD, S_HCHK, S_POP, S_MUL, S_CHK, S_DIV, S_TRD, S_TCHK,
    S_GROW, S_SRD, S_SCHK, S_SPOP, S_FILL
  } state_t;

  localparam ent_t NULL_ENT = '{nul: 1'b1, addr: '0};

  // Round a small size up to a granule; zero acts as one granule
  function automatic logic [NW-1:0] round_size(input logic [15:0] sz);
    logic [16:0] up;
    logic [16:0] r;
    up = {1'b0, sz} + 17'(GRANULE - 1);
    r  = (up >> GB) << GB;
    return (r == 17'd0) ? NW'(GRANULE) : NW'(r);
  endfunction

  function automatic logic [CW-1:0] class_of(input logic [NW:0] r);
    logic [NW:0] t;
    t = (r >> GB) - (NW+1)'(1);
    return t[CW-1:0];
  endfunction

  function automatic logic [LW-1:0] link_idx(input logic [VW-1:0] a);
    return a[GB +: LW];
  endfunction

  state_t              state_r;
  logic                op_r;
  logic [VW-1:0]       addr_r;
  logic [NW-1:0]       n_r;
  logic [CW-1:0]       cls_r;
  logic [CW-1:0]       tcls_r;
  logic [5:0]          refill_r;
  logic [5:0]          objs_r;
  logic [5:0]          k_r;
  logic [5:0]          q_r;
  logic [TW-1:0]       total_r;
  logic [VW-1:0]       rem_r;
  logic [VW-1:0]       start_r;
  logic [VW-1:0]       end_r;
  logic [VW-1:0]       top_r;
  logic [VW-1:0]       grown_r;
  logic [VW-1:0]       res_r;
  logic [VW-1:0]       cur_r;
  logic [VW-1:0]       sh_r;
  logic [NW:0]         s_r;
  logic                out_valid_r;
  sfla_pkg::out_t      out_r;

  // Head memory with per-class valid bits
  ent_t                heads_mem [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] hval_r;
  ent_t                hq_r;
  logic                hv_r;
  logic [CW-1:0]       head_raddr;
  logic                head_we;
  logic [CW-1:0]       head_waddr;
  ent_t                head_wdata;

  // Link memory
  ent_t                links_mem [LINK_DEPTH];
  ent_t                lq_r;
  logic [LW-1:0]       link_raddr;
  logic                link_we;
  logic [LW-1:0]       link_waddr;
  ent_t                link_wdata;

  ent_t                hent;
  logic                hnull;
  logic [VW-1:0]       left;
  logic [GW-1:0]       hg_div;
  logic [GW-1:0]       hg_up;
  logic [GW-1:0]       get;
  logic [GW-1:0]       avail;
  logic [NW-1:0]       in_n;
  logic                in_over;
  logic [5:0]          k_inc;
  logic                k_last;

  assign hent   = hv_r ? hq_r : NULL_ENT;
  assign hnull  = hent.nul;
  assign left   = end_r - start_r;
  assign in_over = (in_data.size > 16'(MAX_SMALL));
  assign in_n   = round_size(in_data.size);
  assign k_inc  = k_r + 6'd1;
  assign k_last = (k_inc == objs_r);

  // Grow amount: twice the need plus a sixteenth of the arena grown so far, granule rounded
  always_comb begin
    hg_div = GW'(grown_r >> 4) + GW'(GRANULE - 1);
    hg_up  = (hg_div >> GB) << GB;
    if (hg_up == '0) begin
      hg_up = GW'(GRANULE);
    end
    get   = GW'({total_r, 1'b0}) + hg_up;
    avail = GW'(POOL_BYTES) - GW'(top_r);
  end

  // Drive memory ports from the current state
  always_comb begin
    head_raddr = cls_r;
    head_we    = 1'b0;
    head_waddr = cls_r;
    head_wdata = '{nul: 1'b0, addr: start_r};
    link_raddr = link_idx(hq_r.addr);
    link_we    = 1'b0;
    link_waddr = link_idx(cur_r);
    link_wdata = hent;
    unique case (state_r)
      S_TRD: head_raddr = tcls_r;
      S_SRD: head_raddr = class_of(s_r);
      S_HCHK: begin
        if (op_r == sfla_pkg::OP_FREE) begin
          head_we    = 1'b1;
          head_wdata = '{nul: 1'b0, addr: addr_r};
          link_we    = 1'b1;
          link_waddr = link_idx(addr_r);
        end
      end
      S_POP: begin
        head_we    = 1'b1;
        head_wdata = lq_r;
      end
      S_TCHK: begin
        head_we    = 1'b1;
        head_waddr = tcls_r;
        link_we    = 1'b1;
        link_waddr = link_idx(start_r);
      end
      S_SPOP: begin
        head_we    = 1'b1;
        head_waddr = class_of(s_r);
        head_wdata = lq_r;
      end
      S_FILL: begin
        if (objs_r != 6'd1) begin
          head_we    = (k_r == 6'd1);
          head_wdata = '{nul: 1'b0, addr: cur_r};
          link_we    = 1'b1;
          link_wdata = k_last ? NULL_ENT : ent_t'{nul: 1'b0, addr: cur_r + VW'(n_r)};
        end
      end
      default: ;
    endcase
  end

  // Head memory: registered read
  always_ff @(posedge clk) begin
    if (head_we) begin
      heads_mem[head_waddr] <= head_wdata;
    end
    hq_r <= heads_mem[head_raddr];
  end

  // Link memory: registered read
  always_ff @(posedge clk) begin
    if (link_we) begin
      links_mem[link_waddr] <= link_wdata;
    end
    lq_r <= links_mem[link_raddr];
  end

  // Head valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hval_r <= '0;
      hv_r   <= 1'b0;
    end else begin
      hv_r <= hval_r[head_raddr];
      if (head_we) begin
        hval_r[head_waddr] <= 1'b1;
      end
    end
  end

  // Sequencer, allocator registers and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      refill_r    <= sfla_pkg::REFILL_RESET;
      start_r     <= '0;
      end_r       <= '0;
      top_r       <= '0;
      grown_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        refill_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r   <= in_data.operation;
            addr_r <= VW'(in_data.address);
            n_r    <= in_n;
            cls_r  <= class_of({1'b0, in_n});
            res_r  <= '0;
            if (in_over) begin
              out_valid_r        <= 1'b1;
              out_r.address_res  <= '0;
              out_r.status       <= sfla_pkg::ST_OVERSIZE;
            end else begin
              state_r <= S_HRD;
            end
          end
        end
        S_HRD: state_r <= S_HCHK;
        S_HCHK: begin
          if (op_r == sfla_pkg::OP_FREE) begin
            out_valid_r       <= 1'b1;
            out_r.address_res <= '0;
            out_r.status      <= sfla_pkg::ST_OK;
            state_r           <= S_IDLE;
          end else if (!hnull) begin
            res_r   <= hq_r.addr;
            state_r <= S_POP;
          end else begin
            if (refill_r == 6'd0) begin
              objs_r <= 6'd1;
            end else if (refill_r > sfla_pkg::REFILL_MAX) begin
              objs_r <= sfla_pkg::REFILL_MAX;
            end else begin
              objs_r <= refill_r;
            end
            state_r <= S_MUL;
          end
        end
        S_POP: begin
          out_valid_r       <= 1'b1;
          out_r.address_res <= res_r[15:0];
          out_r.status      <= sfla_pkg::ST_OK;
          state_r           <= S_IDLE;
        end
        S_MUL: begin
          total_r <= TW'(n_r) * TW'(objs_r);
          state_r <= S_CHK;
        end
        // Check the leftover region against the need
        S_CHK: begin
          if (GW'(left) >= GW'(total_r)) begin
            res_r   <= start_r;
            cur_r   <= start_r + VW'(n_r);
            start_r <= start_r + VW'(total_r);
            k_r     <= 6'd1;
            state_r <= S_FILL;
          end else if (left >= VW'(n_r)) begin
            rem_r   <= left;
            q_r     <= '0;
            state_r <= S_DIV;
          end else if (left != '0) begin
            tcls_r  <= class_of((NW+1)'(left));
            state_r <= S_TRD;
          end else begin
            start_r <= '0;
            end_r   <= '0;
            state_r <= S_GROW;
          end
        end
        // Count how many objects fit in the leftover
        S_DIV: begin
          if (rem_r >= VW'(n_r)) begin
            rem_r <= rem_r - VW'(n_r);
            q_r   <= q_r + 6'd1;
          end else begin
            objs_r  <= q_r;
            res_r   <= start_r;
            cur_r   <= start_r + VW'(n_r);
            start_r <= start_r + (left - rem_r);
            k_r     <= 6'd1;
            state_r <= S_FILL;
          end
        end
        S_TRD: state_r <= S_TCHK;
        // Push the leftover tail, then drop the region
        S_TCHK: begin
          start_r <= '0;
          end_r   <= '0;
          state_r <= S_GROW;
        end
        S_GROW: begin
          if (top_r <= VW'(POOL_BYTES) && get <= avail) begin
            start_r <= top_r;
            end_r   <= top_r + VW'(get);
            top_r   <= top_r + VW'(get);
            grown_r <= grown_r + VW'(get);
            state_r <= S_CHK;
          end else begin
            s_r     <= (NW+1)'(n_r);
            state_r <= S_SRD;
          end
        end
        S_SRD: state_r <= S_SCHK;
        // Steal from the first non-empty list of this size or larger
        S_SCHK: begin
          if (!hnull) begin
            sh_r    <= hq_r.addr;
            state_r <= S_SPOP;
          end else if (s_r + (NW+1)'(GRANULE) > (NW+1)'(MAX_SMALL)) begin
            out_valid_r       <= 1'b1;
            out_r.address_res <= '0;
            out_r.status      <= sfla_pkg::ST_OOM;
            state_r           <= S_IDLE;
          end else begin
            s_r     <= s_r + (NW+1)'(GRANULE);
            state_r <= S_SRD;
          end
        end
        S_SPOP: begin
          start_r <= sh_r;
          end_r   <= sh_r + VW'(s_r);
          state_r <= S_CHK;
        end
        // Chain carved objects onto the list, one link per cycle
        S_FILL: begin
          if (objs_r == 6'd1 || k_last) begin
            out_valid_r       <= 1'b1;
            out_r.address_res <= res_r[15:0];
            out_r.status      <= sfla_pkg::ST_OK;
            state_r           <= S_IDLE;
          end else begin
            cur_r <= cur_r + VW'(n_r);
            k_r   <= k_inc;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SFLA_ASSERT_NOW(a_result_when_idle, out_valid, !busy)
  `SFLA_ASSERT_NEXT(a_accept_goes_busy, start && !busy && !in_over, busy)
  `SFLA_ASSERT_NOW(a_status_code, out_valid, out_data.status <= sfla_pkg::ST_OOM)
  `SFLA_ASSERT_NEXT(a_oversize_no_wait, start && !busy && in_over,
                    out_valid && out_data.status == sfla_pkg::ST_OVERSIZE)

endmodule

FILE: verif/sfla_checker.sv
`timescale 1ns / 100ps

module sfla_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  sfla_pkg::in_t  in_data,
  input  logic           out_valid,
  input  sfla_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [5:0]     cfg_wdata,
  output int             err_count,
  output int             results_owed
);

  localparam int unsigned EMPTY_FLAG = 32'h8000_0000;
  localparam int unsigned NUM_CLASSES = 16;
  localparam int unsigned GRAN = 8;
  localparam int unsigned LINK_ENTRIES = 8192;
  localparam int unsigned POOL_SIZE = 65536;

  int unsigned    list_head[NUM_CLASSES];
  int unsigned    next_link[LINK_ENTRIES];
  int unsigned    spare_lo, spare_hi, bump_top, grown_total;
  logic [5:0]     refill_objs;
  sfla_pkg::out_t owed_results[$];

  function automatic int unsigned to_granule(int unsigned bytes);
    int unsigned r;
    r = ((bytes + GRAN - 1) / GRAN) * GRAN;
    return (r == 0) ? GRAN : r;
  endfunction

  function automatic int unsigned class_for(int unsigned rounded);
    return (rounded / GRAN - 1) % NUM_CLASSES;
  endfunction

  function automatic int unsigned link_slot(int unsigned a);
    return (a / GRAN) % LINK_ENTRIES;
  endfunction

  task automatic push_free(int unsigned cls, int unsigned a);
    next_link[link_slot(a)] = list_head[cls];
    list_head[cls] = a;
  endtask

  // Take a run of objects from the spare region, growing or stealing as needed
  task automatic take_run(input int unsigned n, inout int unsigned objs,
                          output int unsigned chunk, output logic [1:0] st);
    int unsigned total, left, want, s, cls, hd;
    logic stole;
    chunk = 0;
    while (1) begin
      total = n * objs;
      left = spare_hi - spare_lo;
      stole = 1'b0;
      if (left >= total) begin
        chunk = spare_lo;
        spare_lo += total;
        st = sfla_pkg::ST_OK;
        return;
      end
      if (left >= n) begin
        objs = left / n;
        chunk = spare_lo;
        spare_lo += objs * n;
        st = sfla_pkg::ST_OK;
        return;
      end
      // drop the too-small tail onto its own list
      if (left > 0) push_free(class_for(left), spare_lo);
      spare_lo = 0;
      spare_hi = 0;
      want = 2 * total + to_granule(grown_total >> 4);
      if (bump_top <= POOL_SIZE && want <= POOL_SIZE - bump_top) begin
        spare_lo = bump_top;
        spare_hi = bump_top + want;
        bump_top += want;
        grown_total += want;
        continue;
      end
      // arena is exhausted: steal a block from this or a larger class
      for (s = n; s <= NUM_CLASSES * GRAN; s += GRAN) begin
        cls = class_for(s);
        hd = list_head[cls];
        if ((hd & EMPTY_FLAG) == 0) begin
          list_head[cls] = next_link[link_slot(hd)];
          spare_lo = hd;
          spare_hi = hd + s;
          stole = 1'b1;
          break;
        end
      end
      if (!stole) begin
        st = sfla_pkg::ST_OOM;
        return;
      end
    end
  endtask

  task automatic predict_alloc(input sfla_pkg::in_t req, output sfla_pkg::out_t res);
    int unsigned n, cls, hd, objs, chunk, k, cur;
    logic [1:0] st;
    res.address_res = '0;
    res.status = sfla_pkg::ST_OK;
    if (req.size > NUM_CLASSES * GRAN) begin
      res.status = sfla_pkg::ST_OVERSIZE;
    end else if (req.operation == sfla_pkg::OP_FREE) begin
      push_free(class_for(to_granule(req.size)), req.address);
    end else begin
      n = to_granule(req.size);
      cls = class_for(n);
      hd = list_head[cls];
      if ((hd & EMPTY_FLAG) == 0) begin
        res.address_res = hd[15:0];
        list_head[cls] = next_link[link_slot(hd)];
      end else begin
        objs = (refill_objs == 0) ? 1 : (refill_objs > 32) ? 32 : refill_objs;
        take_run(n, objs, chunk, st);
        res.status = st;
        if (st == sfla_pkg::ST_OK) begin
          res.address_res = chunk[15:0];
          // chain the rest of the run onto the class list
          if (objs > 1) begin
            list_head[cls] = chunk + n;
            for (k = 1; k < objs; k++) begin
              cur = chunk + k * n;
              next_link[link_slot(cur)] = (k + 1 == objs) ? EMPTY_FLAG : cur + n;
            end
          end
        end
      end
    end
  endtask

  assign results_owed = owed_results.size();

  always @(posedge clk) begin
    sfla_pkg::out_t exp_res;
    if (!rst_n) begin
      foreach (list_head[i]) list_head[i] = EMPTY_FLAG;
      spare_lo = 0;
      spare_hi = 0;
      bump_top = 0;
      grown_total = 0;
      refill_objs = sfla_pkg::REFILL_RESET;
      owed_results.delete();
      err_count = 0;
    end else begin
      if (cfg_we) refill_objs = cfg_wdata;
      // predict each accepted request beat
      if (start && !busy) begin
        predict_alloc(in_data, exp_res);
        owed_results.push_back(exp_res);
      end
      // compare each result beat with the oldest prediction
      if (out_valid) begin
        if (owed_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("result beat with nothing expected: addr=%h status=%0d",
                     out_data.address_res, out_data.status);
        end else begin
          exp_res = owed_results.pop_front();
          if (exp_res.address_res !== out_data.address_res ||
              exp_res.status !== out_data.status) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: exp addr=%h status=%0d, got addr=%h status=%0d",
                       exp_res.address_res, exp_res.status,
                       out_data.address_res, out_data.status);
          end
        end
      end
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic        is_alloc;
    logic [15:0] size;
  } req_note_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  sfla_pkg::in_t  in_data = '0;
  logic           out_valid;
  sfla_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [5:0]     cfg_wdata = '0;
  int             err_count;
  int             results_owed;

  req_note_t      sent_notes[$];
  logic [15:0]    live_addr[$];
  logic [15:0]    live_size[$];
  int             idle_pct;

  segregated_free_list_allocator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  sfla_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .err_count(err_count), .results_owed(results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Track granted blocks so they can be freed later
  always @(posedge clk) begin
    req_note_t note;
    if (rst_n && out_valid && sent_notes.size() > 0) begin
      note = sent_notes.pop_front();
      if (note.is_alloc && out_data.status == sfla_pkg::ST_OK) begin
        live_addr.push_back(out_data.address_res);
        live_size.push_back(note.size);
      end
    end
  end

  // Drive one request beat and hold it until taken; call at a rising edge
  task automatic send_req(input logic op, input logic [15:0] sz, input logic [15:0] adr);
    req_note_t note;
    start <= 1'b1;
    in_data <= '{operation: op, size: sz, address: adr};
    do @(posedge clk); while (busy);
    note.is_alloc = (op == sfla_pkg::OP_ALLOC);
    note.size = sz;
    sent_notes.push_back(note);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_refill(input logic [5:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_req();
    int pick, idx;
    logic [15:0] sz;
    pick = $urandom_range(99);
    if (pick >= 55 && pick < 90 && live_addr.size() > 0) begin
      // free a block that was really granted
      idx = $urandom_range(live_addr.size() - 1);
      send_req(sfla_pkg::OP_FREE, live_size[idx], live_addr[idx]);
      live_addr.delete(idx);
      live_size.delete(idx);
    end else if (pick >= 90) begin
      // noise: arbitrary address and size
      sz = ($urandom_range(1) != 0) ? 16'($urandom_range(0, 128)) : 16'($urandom);
      send_req(sfla_pkg::OP_FREE, sz, 16'($urandom));
    end else begin
      sz = ($urandom_range(19) == 0) ? 16'($urandom_range(129, 65535))
                                     : 16'($urandom_range(0, 128));
      send_req(sfla_pkg::OP_ALLOC, sz, 16'($urandom));
    end
  endtask

  initial begin
    int pcts[4];
    logic [5:0] refills[6];
    pcts = '{0, 50, 0, 31};
    refills = '{6'd20, 6'd1, 6'd32, 6'd0, 6'd63, 6'd7};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: size extremes, both operations, oversize, unchecked frees
    idle_pct = 0;
    send_req(sfla_pkg::OP_ALLOC, 16'd0, 16'hFFFF);
    send_req(sfla_pkg::OP_ALLOC, 16'd8, 16'd0);
    send_req(sfla_pkg::OP_ALLOC, 16'd128, 16'd0);
    send_req(sfla_pkg::OP_ALLOC, 16'd129, 16'd0);
    send_req(sfla_pkg::OP_ALLOC, 16'hFFFF, 16'hFFFF);
    send_req(sfla_pkg::OP_FREE, 16'hFFFF, 16'h1234);
    send_req(sfla_pkg::OP_FREE, 16'd129, 16'd0);
    send_req(sfla_pkg::OP_FREE, 16'd1, 16'hFFFF);
    send_req(sfla_pkg::OP_ALLOC, 16'd1, 16'd0);
    send_req(sfla_pkg::OP_FREE, 16'd0, 16'h5553);
    send_req(sfla_pkg::OP_ALLOC, 16'd0, 16'd0);
    send_req(sfla_pkg::OP_ALLOC, 16'd127, 16'hAAAA);
    send_req(sfla_pkg::OP_FREE, 16'd120, 16'h0000);
    send_req(sfla_pkg::OP_ALLOC, 16'd113, 16'd0);
    drain();

    // random phases over refill settings and sender idling
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) write_refill(ph == 5 ? 6'($urandom_range(2, 31)) : refills[ph]);
      idle_pct = pcts[ph % 4];
      for (int i = 0; i < 275; i++) random_req();
      drain();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
